// File: sv/cbfa_pkg.sv
`timescale 1ns / 1ps
package cbfa_pkg;

  localparam int ID_W     = 16;
  localparam int SIZE_W   = 20;
  localparam int STATUS_W = 2;
  localparam int START_W  = 7;
  localparam int COUNT_W  = 8;

  // Disk blocks are 512 bytes.
  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SHIFT = 9;
  localparam int NEED_W      = SIZE_W - BLOCK_SHIFT + 1;

  localparam logic ACT_CREATE = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_SCAN,
    S_MARK,
    S_DRD,
    S_DCMP,
    S_FREE,
    S_CRD,
    S_CWR
  } state_t;

endpackage

// File: sv/contiguous_block_file_allocator.sv
`timescale 1ns / 1ps
// Contiguous first-fit file allocator over a free map of NUM_BLOCKS 512-byte blocks and a
// compact table of up to MAX_ENTRIES files. A word is taken when start is high and busy is
// low; busy then stays high until the single result word appears on the out_ ports for one
// cycle, marked by out_valid, and the receiver has no way to stall it. For a create, one
// sequencer walks the free map one block per cycle looking for the first free run, then
// clears the run one block per cycle. For a delete, the table sits in a single-port-read
// memory with a registered read, so the id search steps through each entry in S_DRD and
// S_DCMP and the compaction in S_CRD and S_CWR, with each entry handled by only one of the
// two, and the freed range is set back one block per cycle. No clearing pass is needed after
// reset.
module contiguous_block_file_allocator
  import cbfa_pkg::*;
#(
  parameter int NUM_BLOCKS  = 128,
  parameter int MAX_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_action,
  input  logic [ID_W-1:0]     in_file_id,
  input  logic [SIZE_W-1:0]   in_file_size,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [START_W-1:0]  out_start_block,
  output logic [COUNT_W-1:0]  out_block_count
);

  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int EW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = ID_W + SIZE_W + BW + CW;

  state_t state_r, state_nxt;

  logic [NUM_BLOCKS-1:0] free_r, free_nxt;
  logic [EW-1:0]         files_r, files_nxt;

  logic                  act_r, act_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         run_r, run_nxt;
  logic [CW-1:0]         k_r, k_nxt;
  logic [BW-1:0]         idx_r, idx_nxt;
  logic [BW-1:0]         ptr_r, ptr_nxt;
  logic [BW-1:0]         start_r, start_nxt;
  logic [EW-1:0]         ent_r, ent_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [START_W-1:0]    out_start_r, out_start_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  // File table: one word per entry holding id, size, start block and block count.
  logic [WW-1:0]         tbl_mem [MAX_ENTRIES];
  logic [WW-1:0]         rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [WW-1:0]         mem_wdata;

  logic [SIZE_W:0]       size_rnd;
  logic [NEED_W-1:0]     need_full;
  logic                  tbl_full;
  logic                  too_big;
  logic                  cur_free;
  logic [CW-1:0]         run_inc;
  logic                  scan_hit;
  logic                  scan_last;
  logic                  walk_last;
  logic [BW:0]           start_calc;
  logic [ID_W-1:0]       rd_id;
  logic [BW-1:0]         rd_start;
  logic [CW-1:0]         rd_cnt;
  logic                  id_match;
  logic                  srch_end;
  logic [EW-1:0]         ent_inc;
  logic                  comp_end;

  assign size_rnd   = {1'b0, size_r} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
  assign need_full  = size_rnd[SIZE_W:BLOCK_SHIFT];
  assign tbl_full   = (files_r == EW'(MAX_ENTRIES));
  assign too_big    = (need_full > NEED_W'(NUM_BLOCKS));
  assign cur_free   = free_r[idx_r];
  assign run_inc    = run_r + CW'(1);
  assign scan_hit   = cur_free && (run_inc == cnt_r);
  assign scan_last  = (idx_r == BW'(NUM_BLOCKS - 1));
  assign walk_last  = ((k_r + CW'(1)) == cnt_r);
  // The run ends at the current block, so it began need - 1 blocks earlier.
  assign start_calc = {1'b0, idx_r} + (BW + 1)'(1) - (BW + 1)'(cnt_r);
  assign rd_id      = rdata_r[WW-1 -: ID_W];
  assign rd_start   = rdata_r[CW +: BW];
  assign rd_cnt     = rdata_r[0 +: CW];
  assign id_match   = (rd_id == id_r);
  assign srch_end   = (ent_r == files_r);
  assign ent_inc    = ent_r + EW'(1);
  assign comp_end   = (ent_inc == files_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CHK;
      end
      S_CHK: begin
        if (act_r == ACT_DELETE) begin
          state_nxt = S_DRD;
        end else if (tbl_full || (need_full == '0) || too_big) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_nxt = S_MARK;
        end else if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_MARK: begin
        if (walk_last) state_nxt = S_IDLE;
      end
      S_DRD: begin
        state_nxt = srch_end ? S_IDLE : S_DCMP;
      end
      S_DCMP: begin
        if (!id_match) begin
          state_nxt = S_DRD;
        end else if (rd_cnt == '0) begin
          state_nxt = S_CRD;
        end else begin
          state_nxt = S_FREE;
        end
      end
      S_FREE: begin
        if (walk_last) state_nxt = S_CRD;
      end
      S_CRD: begin
        state_nxt = comp_end ? S_IDLE : S_CWR;
      end
      S_CWR: begin
        state_nxt = S_CRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    free_nxt       = free_r;
    files_nxt      = files_r;
    act_nxt        = act_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    cnt_nxt        = cnt_r;
    run_nxt        = run_r;
    k_nxt          = k_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    start_nxt      = start_r;
    ent_nxt        = ent_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = AW'(files_r);
    mem_raddr      = AW'(ent_r);
    mem_wdata      = {id_r, size_r, start_r, cnt_r};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          id_nxt   = in_file_id;
          size_nxt = in_file_size;
        end
      end
      S_CHK: begin
        cnt_nxt = CW'(need_full);
        idx_nxt = '0;
        run_nxt = '0;
        ent_nxt = '0;
        if (act_r == ACT_CREATE) begin
          if (tbl_full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_TABLE_FULL;
            out_start_nxt  = '0;
            out_count_nxt  = '0;
          end else if (need_full == '0) begin
            mem_we         = 1'b1;
            mem_wdata      = {id_r, size_r, {BW{1'b0}}, {CW{1'b0}}};
            files_nxt      = files_r + EW'(1);
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_start_nxt  = '0;
            out_count_nxt  = '0;
          end else if (too_big) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NO_SPACE;
            out_start_nxt  = '0;
            out_count_nxt  = '0;
          end
        end
      end
      S_SCAN: begin
        run_nxt = cur_free ? run_inc : '0;
        idx_nxt = idx_r + BW'(1);
        if (scan_hit) begin
          start_nxt = start_calc[BW-1:0];
          ptr_nxt   = start_calc[BW-1:0];
          k_nxt     = '0;
          mem_we    = 1'b1;
          mem_wdata = {id_r, size_r, start_calc[BW-1:0], cnt_r};
        end else if (scan_last) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_SPACE;
          out_start_nxt  = '0;
          out_count_nxt  = '0;
        end
      end
      S_MARK: begin
        free_nxt[ptr_r] = 1'b0;
        ptr_nxt         = ptr_r + BW'(1);
        k_nxt           = k_r + CW'(1);
        if (walk_last) begin
          files_nxt      = files_r + EW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = START_W'(start_r);
          out_count_nxt  = COUNT_W'(cnt_r);
        end
      end
      S_DRD: begin
        if (srch_end) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          out_start_nxt  = '0;
          out_count_nxt  = '0;
        end
      end
      S_DCMP: begin
        if (id_match) begin
          start_nxt = rd_start;
          ptr_nxt   = rd_start;
          cnt_nxt   = rd_cnt;
          k_nxt     = '0;
        end else begin
          ent_nxt = ent_inc;
        end
      end
      S_FREE: begin
        free_nxt[ptr_r] = 1'b1;
        ptr_nxt         = ptr_r + BW'(1);
        k_nxt           = k_r + CW'(1);
      end
      S_CRD: begin
        // Fetch the next entry so it can be moved down one slot.
        mem_raddr = AW'(ent_inc);
        if (comp_end) begin
          files_nxt      = files_r - EW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = START_W'(start_r);
          out_count_nxt  = COUNT_W'(cnt_r);
        end
      end
      S_CWR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ent_r);
        mem_wdata = rdata_r;
        ent_nxt   = ent_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '1;
      files_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      files_r     <= files_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    cnt_r        <= cnt_nxt;
    run_r        <= run_nxt;
    k_r          <= k_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    start_r      <= start_nxt;
    ent_r        <= ent_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) tbl_mem[mem_waddr] <= mem_wdata;
    rdata_r <= tbl_mem[mem_raddr];
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;
  assign out_block_count = out_count_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while a request is still in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_table_bound: assert property (@(posedge clk) disable iff (!rst_n)
    files_r <= EW'(MAX_ENTRIES))
    else $error("file table count exceeds its capacity");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_start_block == '0 && out_block_count == '0))
    else $error("error result carries a nonzero block range");

  a_mark_free_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK) |-> free_r[ptr_r])
    else $error("allocation is claiming a block that is already in use");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
  import cbfa_pkg::*;

  localparam int NUM_BLOCKS  = 128;
  localparam int MAX_ENTRIES = 16;
  localparam int N_RANDOM    = 1400;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  start_block;
    logic [COUNT_W-1:0]  block_count;
  } reply_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                start        = 1'b0;
  logic                in_action    = ACT_CREATE;
  logic [ID_W-1:0]     in_file_id   = '0;
  logic [SIZE_W-1:0]   in_file_size = '0;
  logic                busy;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [START_W-1:0]  out_start_block;
  logic [COUNT_W-1:0]  out_block_count;

  // Shadow of the allocator: free map plus the compact file table.
  bit [NUM_BLOCKS-1:0] free_map;
  logic [ID_W-1:0]     tbl_id    [MAX_ENTRIES];
  int                  tbl_start [MAX_ENTRIES];
  int                  tbl_count [MAX_ENTRIES];
  int                  files_held;

  reply_t reply_q[$];
  int     mismatches   = 0;
  int     replies_seen = 0;
  int     n_create     = 0;
  int     n_delete     = 0;
  int     status_hits[4];

  contiguous_block_file_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_file_id     (in_file_id),
    .in_file_size   (in_file_size),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_start_block(out_start_block),
    .out_block_count(out_block_count)
  );

  always #5 clk = ~clk;

  function automatic reply_t predict_reply(logic act, logic [ID_W-1:0] id,
                                           logic [SIZE_W-1:0] sz);
    reply_t r;
    int     need;
    int     run;
    int     base;
    int     idx;
    int     b;
    bit     hit;
    r = '0;
    if (act == ACT_CREATE) begin
      n_create++;
      if (files_held >= MAX_ENTRIES) begin
        r.status = ST_TABLE_FULL;
      end else begin
        need = (int'(sz) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        hit  = (need == 0);
        base = 0;
        run  = 0;
        for (b = 0; b < NUM_BLOCKS && !hit; b++) begin
          if (free_map[b]) begin
            run++;
            if (run == need) begin
              base = b + 1 - need;
              hit  = 1'b1;
            end
          end else begin
            run = 0;
          end
        end
        if (!hit) begin
          r.status = ST_NO_SPACE;
        end else begin
          for (b = base; b < base + need; b++) free_map[b] = 1'b0;
          tbl_id[files_held]    = id;
          tbl_start[files_held] = base;
          tbl_count[files_held] = need;
          files_held++;
          r.status      = ST_OK;
          r.start_block = base[START_W-1:0];
          r.block_count = need[COUNT_W-1:0];
        end
      end
    end else begin
      n_delete++;
      idx = -1;
      for (b = 0; b < files_held && idx < 0; b++)
        if (tbl_id[b] == id) idx = b;
      if (idx < 0) begin
        r.status = ST_NOT_FOUND;
      end else begin
        r.status      = ST_OK;
        r.start_block = tbl_start[idx][START_W-1:0];
        r.block_count = tbl_count[idx][COUNT_W-1:0];
        for (b = tbl_start[idx]; b < tbl_start[idx] + tbl_count[idx]; b++) free_map[b] = 1'b1;
        // Later entries slide down one place to keep the table compact.
        for (b = idx; b + 1 < files_held; b++) begin
          tbl_id[b]    = tbl_id[b + 1];
          tbl_start[b] = tbl_start[b + 1];
          tbl_count[b] = tbl_count[b + 1];
        end
        files_held--;
      end
    end
    status_hits[r.status]++;
    return r;
  endfunction

  task automatic flag_mismatch(string what, reply_t want, reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status %0d start %0d count %0d, got status %0d start %0d count %0d",
               $time, what, want.status, want.start_block, want.block_count,
               got.status, got.start_block, got.block_count);
  endtask

  always @(posedge clk) begin : check_replies
    reply_t got;
    reply_t want;
    if (rst_n && out_valid) begin
      got = {out_status, out_start_block, out_block_count};
      replies_seen++;
      if (reply_q.size() == 0) begin
        flag_mismatch("unexpected result word", '0, got);
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.start_block !== want.start_block ||
            got.block_count !== want.block_count)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Holds start high until the word is taken, then drops it on the next falling edge.
  task automatic send_word(logic act, logic [ID_W-1:0] id, logic [SIZE_W-1:0] sz);
    @(negedge clk);
    start        <= 1'b1;
    in_action    <= act;
    in_file_id   <= id;
    in_file_size <= sz;
    do @(posedge clk); while (busy);
    reply_q.push_back(predict_reply(act, id, sz));
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_drained;
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed;
    send_word(ACT_CREATE, 16'h0000, 20'd0);
    send_word(ACT_CREATE, 16'hFFFF, 20'd1);
    send_word(ACT_CREATE, 16'h1234, 20'd512);
    send_word(ACT_CREATE, 16'h1234, 20'd513);
    send_word(ACT_CREATE, 16'h0007, 20'hFFFFF);
    send_word(ACT_DELETE, 16'hABCD, 20'hFFFFF);
    send_word(ACT_DELETE, 16'h1234, 20'd0);
    // Needs two blocks; the single free block left behind must be skipped.
    send_word(ACT_CREATE, 16'h0009, 20'd1024);
    send_word(ACT_DELETE, 16'h0000, 20'd0);
    send_word(ACT_DELETE, 16'hFFFF, 20'd0);
    send_word(ACT_DELETE, 16'h1234, 20'd0);
    send_word(ACT_DELETE, 16'h0009, 20'd0);
    send_word(ACT_CREATE, 16'h8000, 20'd65536);
    send_word(ACT_CREATE, 16'h0001, 20'd1);
    send_word(ACT_DELETE, 16'h8000, 20'd0);
  endtask

  task automatic test_table_full;
    for (int k = 0; k < MAX_ENTRIES; k++)
      send_word(ACT_CREATE, ID_W'(16'h0100 + k), SIZE_W'($urandom_range(0, 1024)));
    send_word(ACT_CREATE, 16'h0200, 20'd0);
    send_word(ACT_CREATE, 16'h0201, 20'hFFFFF);
    send_word(ACT_DELETE, ID_W'(16'h0100 + MAX_ENTRIES - 1), 20'd0);
    send_word(ACT_DELETE, 16'h0100, 20'd0);
    send_word(ACT_DELETE, 16'h0107, 20'd0);
  endtask

  task automatic send_random_word;
    logic            act;
    logic [ID_W-1:0] id;
    logic [SIZE_W-1:0] sz;
    // Deletes grow likelier as the table fills, so both full and empty tables come up.
    act = ($urandom_range(0, 99) < 25 + 3 * files_held) ? ACT_DELETE : ACT_CREATE;
    if (act == ACT_DELETE) begin
      if (files_held > 0 && $urandom_range(0, 4) != 0)
        id = tbl_id[$urandom_range(0, files_held - 1)];
      else
        id = ID_W'($urandom_range(0, 15));
      sz = SIZE_W'($urandom);
    end else begin
      id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
      case ($urandom_range(0, 19))
        0:       sz = '0;
        1:       sz = SIZE_W'($urandom);
        2, 3:    sz = SIZE_W'($urandom_range(1, 65536));
        4:       sz = SIZE_W'(BLOCK_BYTES * $urandom_range(1, 16) + $urandom_range(0, 2) - 1);
        default: sz = SIZE_W'($urandom_range(1, 4096));
      endcase
    end
    send_word(act, id, sz);
  endtask

  task automatic test_random;
    int sent;
    int burst;
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
        send_random_word();
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        9:          wait_drained();
        default:    repeat ($urandom_range(1, 160)) @(negedge clk);
      endcase
    end
  endtask

  initial begin
    free_map   = '1;
    files_held = 0;
    for (int k = 0; k < 4; k++) status_hits[k] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_table_full();
    wait_drained();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d creates and %0d deletes, %0d result words checked.",
             n_create, n_delete, replies_seen);
    $display("Statuses seen: ok %0d, table full %0d, no space %0d, not found %0d.",
             status_hits[ST_OK], status_hits[ST_TABLE_FULL], status_hits[ST_NO_SPACE],
             status_hits[ST_NOT_FOUND]);
    if (mismatches == 0)
      $display("contiguous_block_file_allocator test passed");
    else
      $display("contiguous_block_file_allocator test failed");
    $finish;
  end

  initial begin
    #30ms;
    $display("Timed out with %0d result words outstanding.", reply_q.size());
    $display("contiguous_block_file_allocator test failed");
    $finish;
  end

endmodule
